[rtl/olte_pkg.sv]
`timescale 1ns / 1ps
package olte_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int CNT_W = 7;
   localparam int IDX_W = $clog2(MAX_ENTRIES);

   localparam logic [2:0] CMD_APPEND    = 3'd0;
   localparam logic [2:0] CMD_REMOVE_VAL = 3'd1;
   localparam logic [2:0] CMD_REMOVE_AT = 3'd2;
   localparam logic [2:0] CMD_REPLACE   = 3'd3;
   localparam logic [2:0] CMD_WRITE_AT  = 3'd4;
   localparam logic [2:0] CMD_READ_AT   = 3'd5;
   localparam logic [2:0] CMD_COUNT     = 3'd6;
   localparam logic [2:0] CMD_CLEAR     = 3'd7;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_BADPOS = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;

   typedef struct packed {
      logic [2:0]         command;
      logic [6:0]         position;
      logic signed [31:0] value;
      logic signed [31:0] new_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_data;
      logic [6:0]         match_count;
      logic [6:0]         entry_count;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic shift;
      logic push;
   } ctl_type;

endpackage

[rtl/olte_cell.sv]
`timescale 1ns / 1ps
module olte_cell
   import olte_pkg::*;
(
   input  logic               clock,
   input  ctl_type            ctl,
   input  logic               sel,
   input  logic signed [31:0] nxt,
   input  logic signed [31:0] fb,
   output logic signed [31:0] data
);

   logic signed [31:0] data_ff;

   always_ff @(posedge clock) begin
      // on a push the selected tail cell takes the fed-back item; on a shift the rest move toward the head
      if (sel && ctl.push) begin
         data_ff <= fb;
      end else if (ctl.shift) begin
         data_ff <= nxt;
      end
   end

   assign data = data_ff;

endmodule

[rtl/ordered_list_table_engine_core.sv]
`timescale 1ns / 1ps
// Channel  | Ports                  | Handshake
// ---------+------------------------+----------------------------------
// command  | req_item, start, busy  | taken when start & !busy
// result   | rsp_item, rsp_valid    | one cycle per item, no backpressure
//
// Entries sit in a row of cells that rotates toward cell 0 one place a cycle
// while scanning. Append, clear, bad positions and empty-list commands end
// without a scan; remove, replace, write, read and count lap the held entries.
// The result appears the cycle after the last step; busy drops with it.
// Synchronous reset empties the list; cell contents are left as they are.
module ordered_list_table_engine_core
   import olte_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_item,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_SCAN = 1'b1;

   logic               state_ff, state_in;
   logic [CNT_W-1:0]   occ_ff, occ_in;
   logic [CNT_W-1:0]   len_ff, len_in;
   logic [CNT_W-1:0]   step_ff, step_in;
   logic [CNT_W-1:0]   match_ff, match_in;
   logic signed [31:0] rdata_ff, rdata_in;
   req_type            req_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   ctl_type            ctl;
   logic [IDX_W-1:0]   tail_idx;
   logic signed [31:0] fb;
   logic signed [31:0] cell_data [MAX_ENTRIES];
   logic signed [31:0] head;
   logic               hit, pos_hit, accept, pos_ok;
   logic [CNT_W-1:0]   len_after;

   assign head    = cell_data[0];
   assign accept  = start && (state_ff == S_IDLE);
   assign hit     = (head == req_ff.value);
   assign pos_hit = ((step_ff + CNT_W'(1)) == req_ff.position);
   assign pos_ok  = (req_item.position != '0) && (req_item.position <= occ_ff);

   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      len_in       = len_ff;
      step_in      = step_ff;
      match_in     = match_ff;
      rdata_in     = rdata_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ctl          = '0;
      fb           = head;
      tail_idx     = IDX_W'(len_ff - CNT_W'(1));
      len_after    = len_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               rsp_in.status = ST_OK;
               len_in   = occ_ff;
               step_in  = '0;
               match_in = '0;
               rdata_in = '0;
               case (req_item.command)
                  CMD_APPEND: begin
                     if (occ_ff == CNT_W'(MAX_ENTRIES)) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        ctl.push = 1'b1;
                        fb       = req_item.value;
                        tail_idx = occ_ff[IDX_W-1:0];
                        occ_in   = occ_ff + CNT_W'(1);
                     end
                  end
                  CMD_CLEAR: begin
                     occ_in = '0;
                  end
                  CMD_REMOVE_AT, CMD_WRITE_AT, CMD_READ_AT: begin
                     if (pos_ok) begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_SCAN;
                     end else begin
                        rsp_in.status = ST_BADPOS;
                     end
                  end
                  default: begin
                     if (occ_ff != '0) begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_SCAN;
                     end
                  end
               endcase
               rsp_in.entry_count = occ_in;
            end
         end
         S_SCAN: begin
            // pop the head, push it back (possibly altered) or drop it
            ctl.shift = 1'b1;
            ctl.push  = 1'b1;
            case (req_ff.command)
               CMD_REMOVE_VAL: ctl.push = !hit;
               CMD_REMOVE_AT:  ctl.push = !pos_hit;
               CMD_REPLACE:    fb = hit ? req_ff.new_value : head;
               CMD_WRITE_AT:   fb = pos_hit ? req_ff.value : head;
               CMD_READ_AT: begin
                  if (pos_hit) rdata_in = head;
               end
               CMD_COUNT: begin
                  if (hit) match_in = match_ff + CNT_W'(1);
               end
               default: ;
            endcase
            if (!ctl.push) len_after = len_ff - CNT_W'(1);
            len_in  = len_after;
            step_in = step_ff + CNT_W'(1);
            if (step_in == occ_ff) begin
               state_in           = S_IDLE;
               occ_in             = len_after;
               rsp_valid_in       = 1'b1;
               rsp_in.read_data   = rdata_in;
               rsp_in.match_count = match_in;
               rsp_in.entry_count = len_after;
               rsp_in.status      = ST_OK;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_item;
      len_ff   <= len_in;
      step_ff  <= step_in;
      match_ff <= match_in;
      rdata_ff <= rdata_in;
      rsp_ff   <= rsp_in;
   end

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic signed [31:0] nxt;
      if (i == MAX_ENTRIES - 1) begin : g_last
         assign nxt = fb;
      end else begin : g_mid
         assign nxt = cell_data[i+1];
      end
      olte_cell u_cell (
         .clock (clock),
         .ctl   (ctl),
         .sel   (tail_idx == IDX_W'(i)),
         .nxt   (nxt),
         .fb    (fb),
         .data  (cell_data[i])
      );
   end

   assign busy      = (state_ff == S_SCAN);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

[verif/ordered_list_table_engine_core_test.sv]
`timescale 1ns / 1ps
module ordered_list_table_engine_core_test;
   import olte_pkg::*;

   logic    clock;
   logic    reset;
   logic    start;
   req_type req_item;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_item;

   ordered_list_table_engine_core dut (
      .clock(clock), .reset(reset), .start(start), .req_item(req_item),
      .busy(busy), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   // shadow copy of the list
   logic [31:0] list_words [MAX_ENTRIES];
   int          list_len;

   req_type pending_cmds[$];
   rsp_type expected_rsps[$];
   int      error_count;
   int      mismatch_count;
   longint  cycle_count;
   bit      quiet_mode;
   bit      hold_off;
   int      send_gap;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic rsp_type apply_command(req_type c);
      rsp_type r;
      int      k;
      r = '0;
      r.status = ST_OK;
      case (c.command)
         CMD_APPEND: begin
            if (list_len >= MAX_ENTRIES) begin
               r.status = ST_FULL;
            end else begin
               list_words[list_len] = c.value;
               list_len++;
            end
         end
         CMD_REMOVE_VAL: begin
            k = 0;
            for (int i = 0; i < list_len; i++)
               if (list_words[i] != c.value) begin
                  list_words[k] = list_words[i];
                  k++;
               end
            list_len = k;
         end
         CMD_REMOVE_AT: begin
            if (c.position >= 1 && c.position <= list_len) begin
               for (int i = c.position - 1; i + 1 < list_len; i++)
                  list_words[i] = list_words[i + 1];
               list_len--;
            end else begin
               r.status = ST_BADPOS;
            end
         end
         CMD_REPLACE: begin
            for (int i = 0; i < list_len; i++)
               if (list_words[i] == c.value) list_words[i] = c.new_value;
         end
         CMD_WRITE_AT: begin
            if (c.position >= 1 && c.position <= list_len)
               list_words[c.position - 1] = c.value;
            else
               r.status = ST_BADPOS;
         end
         CMD_READ_AT: begin
            if (c.position >= 1 && c.position <= list_len)
               r.read_data = list_words[c.position - 1];
            else
               r.status = ST_BADPOS;
         end
         CMD_COUNT: begin
            k = 0;
            for (int i = 0; i < list_len; i++)
               if (list_words[i] == c.value) k++;
            r.match_count = 7'(k);
         end
         default: list_len = 0;
      endcase
      r.entry_count = 7'(list_len);
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         req_item <= '0;
         send_gap <= 0;
      end else if (start && busy) begin
         // hold until taken
      end else begin
         if (start) expected_rsps.push_back(apply_command(req_item));
         if (send_gap > 0) begin
            start    <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pending_cmds.size() > 0 && !hold_off) begin
            start    <= 1'b1;
            req_item <= pending_cmds.pop_front();
            if (!quiet_mode && $urandom_range(0, 5) == 0)
               send_gap <= $urandom_range(1, 19);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            error_count++;
            if (mismatch_count < 10) $display("unexpected result %p", rsp_item);
            mismatch_count++;
         end else begin
            rsp_type want;
            want = expected_rsps.pop_front();
            if (rsp_item !== want) begin
               error_count++;
               if (mismatch_count < 10)
                  $display("mismatch: expected %p actual %p", want, rsp_item);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 3))
         0: return 32'($urandom_range(0, 3));
         1: return $urandom();
         2: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff};
         default: return 32'($urandom_range(0, 3)) ^ 32'hffff_fffc;
      endcase
   endfunction

   task automatic add_cmd(logic [2:0] op, int pos, logic [31:0] v, logic [31:0] nv);
      req_type c;
      c.command   = op;
      c.position  = 7'(pos);
      c.value     = v;
      c.new_value = nv;
      pending_cmds.push_back(c);
   endtask

   task automatic add_random_cmd();
      logic [2:0] op;
      int         pos;
      op = $urandom_range(0, 9) < 3 ? CMD_APPEND : 3'($urandom_range(0, 7));
      // rare clear keeps the list long
      if (op == CMD_CLEAR && $urandom_range(0, 3) != 0) op = CMD_APPEND;
      pos = $urandom_range(0, 9) == 0 ? $urandom_range(0, 127) : $urandom_range(0, 66);
      add_cmd(op, pos, pick_value(), $urandom());
   endtask

   initial begin
      error_count    = 0;
      mismatch_count = 0;
      cycle_count    = 0;
      list_len       = 0;
      quiet_mode     = 1'b0;
      hold_off       = 1'b0;
      reset          = 1'b1;
      start          = 1'b0;
      req_item       = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty store cases, extremes, every command
      add_cmd(CMD_REMOVE_VAL, 0, 32'h0, 32'h0);
      add_cmd(CMD_COUNT, 0, 32'h0, 32'h0);
      add_cmd(CMD_REPLACE, 0, 32'h0, 32'h1);
      add_cmd(CMD_READ_AT, 1, 32'h0, 32'h0);
      add_cmd(CMD_CLEAR, 0, 32'h0, 32'h0);
      add_cmd(CMD_APPEND, 0, 32'h8000_0000, 32'h0);
      add_cmd(CMD_APPEND, 127, 32'h7fff_ffff, 32'hffff_ffff);
      add_cmd(CMD_APPEND, 0, 32'h8000_0000, 32'h0);
      add_cmd(CMD_READ_AT, 0, 32'h0, 32'h0);
      add_cmd(CMD_READ_AT, 3, 32'h0, 32'h0);
      add_cmd(CMD_READ_AT, 4, 32'h0, 32'h0);
      add_cmd(CMD_WRITE_AT, 2, 32'hffff_ffff, 32'h0);
      add_cmd(CMD_WRITE_AT, 127, 32'h1, 32'h0);
      add_cmd(CMD_COUNT, 0, 32'h8000_0000, 32'h0);
      add_cmd(CMD_REPLACE, 0, 32'h8000_0000, 32'h7fff_ffff);
      add_cmd(CMD_REMOVE_AT, 1, 32'h0, 32'h0);
      add_cmd(CMD_REMOVE_AT, 0, 32'h0, 32'h0);
      add_cmd(CMD_REMOVE_VAL, 0, 32'h7fff_ffff, 32'h0);
      add_cmd(CMD_READ_AT, 1, 32'h0, 32'h0);
      add_cmd(CMD_CLEAR, 0, 32'h0, 32'h0);
      // fill to full, overflow, then read the far end
      for (int i = 0; i < MAX_ENTRIES + 2; i++)
         add_cmd(CMD_APPEND, 0, 32'(i % 5), 32'h0);
      add_cmd(CMD_READ_AT, 64, 32'h0, 32'h0);
      add_cmd(CMD_READ_AT, 65, 32'h0, 32'h0);
      add_cmd(CMD_REMOVE_AT, 64, 32'h0, 32'h0);
      add_cmd(CMD_COUNT, 0, 32'h0, 32'h0);
      add_cmd(CMD_REMOVE_VAL, 0, 32'h3, 32'h0);
      for (int i = 0; i < 200; i++) add_random_cmd();
      wait (pending_cmds.size() == 0 && !start);

      // drain fully before continuing
      hold_off = 1'b1;
      wait (expected_rsps.size() == 0);
      @(posedge clock);
      hold_off = 1'b0;

      for (int i = 0; i < 160; i++) add_random_cmd();
      wait (pending_cmds.size() == 0 && !start);
      quiet_mode = 1'b1;
      for (int i = 0; i < 100; i++) add_random_cmd();
      wait (pending_cmds.size() == 0 && !start);
      wait (expected_rsps.size() == 0);
      repeat (80) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/olte_pkg.sv
rtl/olte_cell.sv
rtl/ordered_list_table_engine_core.sv
verif/ordered_list_table_engine_core_test.sv
